// File: design/twewq_pkg.sv
// Package with shared types, constants and a helper function of the event window queue.
package twewq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 64;
  localparam int unsigned TIME_BITS_DEF    = 48;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;
  localparam int unsigned TYPE_COUNT_DEF   = 8;

  localparam int unsigned TYPE_BITS   = 3;
  localparam int unsigned ID_BITS     = 32;
  localparam int unsigned LEN_BITS    = 16;
  localparam int unsigned MAXC_BITS   = 7;
  localparam int unsigned PRIO_BITS   = 4;
  localparam int unsigned HIT_DEPTH   = 64;
  localparam int unsigned HIT_AW      = 6;
  localparam int unsigned CFG_BITS    = 32;
  localparam logic [CFG_BITS-1:0] PRIO_TABLE_RESET = 32'h7654_3210;
  localparam logic [PRIO_BITS-1:0] PRIO_UNKNOWN    = 4'hF;

  typedef enum logic [1:0] {
    ST_STORED    = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_DELIVERED = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCHED,
    S_NONE,
    S_DRAIN,
    S_SCAN,
    S_EMIT
  } fsm_e;

  typedef enum logic {
    KIND_SCHEDULE = 1'b0,
    KIND_POP      = 1'b1
  } kind_e;

  // Priority of one event type; types outside the table sort last.
  function automatic logic [PRIO_BITS-1:0] prio_of(input logic [CFG_BITS-1:0] tbl,
                                                   input logic [TYPE_BITS-1:0] ty,
                                                   input int unsigned type_count);
    logic [PRIO_BITS-1:0] p;
    p = tbl[{ty, 2'b00} +: PRIO_BITS];
    if (int'(ty) >= int'(type_count)) p = PRIO_UNKNOWN;
    return p;
  endfunction

endpackage

// File: design/timestamped_event_window_queue_unit.sv
// Top level of the timestamped event window queue with its sequencer and storage.
//
//  channel   | direction | handshake                      | contents
//  ----------+-----------+--------------------------------+----------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | schedule or pop request
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | status, id and delivered event
//  cfg       | in        | cfg_valid_i / cfg_ready_o      | type priority table (4 bits/type)
//
// A pop drains the queue through its single read port, then takes each delivered event
// from one selection scan over the hit store. Reset clears the pointers, the fill count
// and the id counter; the storage needs no clearing pass because only written entries
// are ever read. A stalled output holds the sequencer in its scheduling, no-result or
// emitting state; a new request is taken whenever the sequencer is idle.
module timestamped_event_window_queue_unit #(
  parameter int unsigned QueueDepth  = twewq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TimeBits    = twewq_pkg::TIME_BITS_DEF,
  parameter int unsigned PayloadBits = twewq_pkg::PAYLOAD_BITS_DEF,
  parameter int unsigned TypeCount   = twewq_pkg::TYPE_COUNT_DEF,
  localparam int unsigned InW  = 2 * TimeBits + twewq_pkg::TYPE_BITS + PayloadBits
                                 + twewq_pkg::LEN_BITS + twewq_pkg::MAXC_BITS,
  localparam int unsigned InTW = ((InW + 7) / 8) * 8,
  localparam int unsigned OutW = twewq_pkg::ID_BITS + TimeBits + twewq_pkg::TYPE_BITS
                                 + PayloadBits,
  localparam int unsigned OutTW = ((OutW + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // event_time, event_type, event_payload, window_start, window_length, max_count
  input  logic [InTW-1:0]                    s_axis_tdata,
  // kind
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // out_id, out_time, out_type, out_payload
  output logic [OutTW-1:0]                   m_axis_tdata,
  // status
  output logic [1:0]                         m_axis_tuser,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [twewq_pkg::CFG_BITS-1:0]     cfg_data_i
);
  import twewq_pkg::*;

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam int unsigned HW = HIT_AW + 1;

  // Bit offsets of the request fields in s_axis_tdata.
  localparam int unsigned OffType  = TimeBits;
  localparam int unsigned OffPay   = OffType + TYPE_BITS;
  localparam int unsigned OffStart = OffPay + PayloadBits;
  localparam int unsigned OffLen   = OffStart + TimeBits;
  localparam int unsigned OffMax   = OffLen + LEN_BITS;

  localparam logic [AW:0] DepthW = (AW + 1)'(QueueDepth);
  localparam logic [HW-1:0] HitLimit = HW'(HIT_DEPTH);

  // Queue storage.
  logic [TimeBits-1:0]    q_time [QueueDepth];
  logic [TYPE_BITS-1:0]   q_type [QueueDepth];
  logic [PayloadBits-1:0] q_pay  [QueueDepth];
  logic [ID_BITS-1:0]     q_id   [QueueDepth];

  // Hit store, holding the events of the current pop that fall inside the window.
  logic [TimeBits-1:0]    h_time [HIT_DEPTH];
  logic [TYPE_BITS-1:0]   h_type [HIT_DEPTH];
  logic [PayloadBits-1:0] h_pay  [HIT_DEPTH];
  logic [ID_BITS-1:0]     h_id   [HIT_DEPTH];
  logic [PRIO_BITS-1:0]   h_prio [HIT_DEPTH];

  fsm_e                  state_q, state_d;
  logic [AW-1:0]         rp_q, rp_d, base_q, base_d, wp_q, wp_d;
  logic [CW-1:0]         fill_q, fill_d, n_q, n_d, i_q, i_d;
  logic [ID_BITS-1:0]    id_q, id_d;
  logic [CFG_BITS-1:0]   prio_tbl_q, prio_tbl_d;
  logic                  rd_pend_q, rd_pend_d;
  logic [HW-1:0]         got_q, got_d, lim_q, lim_d, scan_q, scan_d, emit_q, emit_d;
  logic [HIT_DEPTH-1:0]  done_q, done_d;
  logic                  best_v_q, best_v_d;
  logic                  out_valid_q, out_valid_d;

  // Payload registers, no reset.
  logic [TimeBits-1:0]    ev_time_q, win_start_q;
  logic [TimeBits:0]      win_end_q;
  logic [TYPE_BITS-1:0]   ev_type_q;
  logic [PayloadBits-1:0] ev_pay_q;
  logic [TimeBits-1:0]    qr_time_q, hr_time_q, best_time_q;
  logic [TYPE_BITS-1:0]   qr_type_q, hr_type_q, best_type_q;
  logic [PayloadBits-1:0] qr_pay_q, hr_pay_q, best_pay_q;
  logic [ID_BITS-1:0]     qr_id_q, hr_id_q, best_id_q;
  logic [PRIO_BITS-1:0]   hr_prio_q, best_prio_q;
  logic [HIT_AW-1:0]      hr_addr_q, best_addr_q;
  logic [1:0]             out_status_q, out_status_d;
  logic [ID_BITS-1:0]     out_id_q, out_id_d;
  logic [TimeBits-1:0]    out_time_q, out_time_d;
  logic [TYPE_BITS-1:0]   out_type_q, out_type_d;
  logic [PayloadBits-1:0] out_pay_q, out_pay_d;
  logic                   out_last_q, out_last_d;

  // Combinational control signals.
  logic                   in_acc, out_free, out_load, best_upd, hit, less;
  logic [AW:0]            rd_sum, tail_sum, push_sum;
  logic [AW-1:0]          rd_addr, tail_addr, push_addr;
  logic                   q_we, h_we;
  logic [AW-1:0]          q_waddr;
  logic [TimeBits-1:0]    q_wtime;
  logic [TYPE_BITS-1:0]   q_wtype;
  logic [PayloadBits-1:0] q_wpay;
  logic [ID_BITS-1:0]     q_wid;
  logic [HW-1:0]          max_in;
  logic [TimeBits-1:0]    start_in;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign max_in        = s_axis_tdata[OffMax +: MAXC_BITS];
  assign start_in      = s_axis_tdata[OffStart +: TimeBits];

  // Circular address arithmetic; every sum stays below twice the depth.
  always_comb begin
    rd_sum    = {1'b0, base_q} + {1'b0, i_q[AW-1:0]};
    rd_addr   = (rd_sum >= DepthW) ? AW'(rd_sum - DepthW) : rd_sum[AW-1:0];
    tail_sum  = {1'b0, rp_q} + {1'b0, fill_q[AW-1:0]};
    tail_addr = (tail_sum >= DepthW) ? AW'(tail_sum - DepthW) : tail_sum[AW-1:0];
    push_sum  = {1'b0, wp_q} + (AW + 1)'(1);
    push_addr = (push_sum >= DepthW) ? AW'(push_sum - DepthW) : push_sum[AW-1:0];
  end

  assign hit  = (qr_time_q >= win_start_q) && ({1'b0, qr_time_q} < win_end_q);
  assign less = (hr_time_q < best_time_q) ||
                ((hr_time_q == best_time_q) && (hr_prio_q < best_prio_q));

  always_comb begin
    state_d      = state_q;
    rp_d         = rp_q;
    base_d       = base_q;
    wp_d         = wp_q;
    fill_d       = fill_q;
    n_d          = n_q;
    i_d          = i_q;
    id_d         = id_q;
    prio_tbl_d   = prio_tbl_q;
    rd_pend_d    = 1'b0;
    got_d        = got_q;
    lim_d        = lim_q;
    scan_d       = scan_q;
    emit_d       = emit_q;
    done_d       = done_q;
    best_v_d     = best_v_q;
    out_valid_d  = out_valid_q;
    out_load     = 1'b0;
    best_upd     = 1'b0;
    q_we         = 1'b0;
    h_we         = 1'b0;
    q_waddr      = tail_addr;
    q_wtime      = ev_time_q;
    q_wtype      = ev_type_q;
    q_wpay       = ev_pay_q;
    q_wid        = id_q;
    out_status_d = ST_NONE;
    out_id_d     = '0;
    out_time_d   = '0;
    out_type_d   = '0;
    out_pay_d    = '0;
    out_last_d   = 1'b1;

    if (cfg_valid_i) prio_tbl_d = cfg_data_i;
    if (out_valid_q && m_axis_tready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (kind_e'(s_axis_tuser) == KIND_SCHEDULE) begin
            state_d = S_SCHED;
          end else if (fill_q == '0 || max_in == '0) begin
            state_d = S_NONE;
          end else begin
            // Drain the whole queue; requeued events land behind the old tail.
            lim_d   = (max_in > HitLimit) ? HitLimit : max_in;
            base_d  = rp_q;
            rp_d    = tail_addr;
            wp_d    = tail_addr;
            n_d     = fill_q;
            fill_d  = '0;
            i_d     = '0;
            got_d   = '0;
            state_d = S_DRAIN;
          end
        end
      end
      S_SCHED: begin
        if (out_free) begin
          id_d     = id_q + ID_BITS'(1);
          out_load = 1'b1;
          out_id_d = id_q;
          if (fill_q < CW'(QueueDepth)) begin
            q_we         = 1'b1;
            fill_d       = fill_q + CW'(1);
            out_status_d = ST_STORED;
          end else begin
            out_status_d = ST_DROPPED;
          end
          state_d = S_IDLE;
        end
      end
      S_NONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (i_q != n_q) begin
          i_d       = i_q + CW'(1);
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          if (hit) begin
            if (got_q < lim_q) begin
              h_we  = 1'b1;
              got_d = got_q + HW'(1);
            end
          end else begin
            q_we    = 1'b1;
            q_waddr = wp_q;
            q_wtime = qr_time_q;
            q_wtype = qr_type_q;
            q_wpay  = qr_pay_q;
            id_d    = id_q + ID_BITS'(1);
            wp_d    = push_addr;
            fill_d  = fill_q + CW'(1);
          end
        end
        if (i_q == n_q && !rd_pend_q) begin
          scan_d   = '0;
          emit_d   = '0;
          done_d   = '0;
          best_v_d = 1'b0;
          state_d  = (got_q == '0) ? S_NONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_q != got_q) begin
          scan_d    = scan_q + HW'(1);
          rd_pend_d = 1'b1;
        end
        // Strict compare keeps the earliest entry on ties, which is queue order.
        if (rd_pend_q && !done_q[hr_addr_q] && (!best_v_q || less)) begin
          best_upd = 1'b1;
          best_v_d = 1'b1;
        end
        if (scan_q == got_q && !rd_pend_q) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load              = 1'b1;
          out_status_d          = ST_DELIVERED;
          out_id_d              = best_id_q;
          out_time_d            = best_time_q;
          out_type_d            = best_type_q;
          out_pay_d             = best_pay_q;
          out_last_d            = (emit_q + HW'(1) == got_q);
          done_d[best_addr_q]   = 1'b1;
          emit_d                = emit_q + HW'(1);
          best_v_d              = 1'b0;
          scan_d                = '0;
          state_d               = out_last_d ? S_IDLE : S_SCAN;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      base_q      <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      n_q         <= '0;
      i_q         <= '0;
      id_q        <= '0;
      prio_tbl_q  <= PRIO_TABLE_RESET;
      rd_pend_q   <= 1'b0;
      got_q       <= '0;
      lim_q       <= '0;
      scan_q      <= '0;
      emit_q      <= '0;
      done_q      <= '0;
      best_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      base_q      <= base_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      n_q         <= n_d;
      i_q         <= i_d;
      id_q        <= id_d;
      prio_tbl_q  <= prio_tbl_d;
      rd_pend_q   <= rd_pend_d;
      got_q       <= got_d;
      lim_q       <= lim_d;
      scan_q      <= scan_d;
      emit_q      <= emit_d;
      done_q      <= done_d;
      best_v_q    <= best_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request capture, selection candidate and output payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ev_time_q   <= s_axis_tdata[TimeBits-1:0];
      ev_type_q   <= s_axis_tdata[OffType +: TYPE_BITS];
      ev_pay_q    <= s_axis_tdata[OffPay +: PayloadBits];
      win_start_q <= start_in;
      win_end_q   <= {1'b0, start_in} + (TimeBits + 1)'(s_axis_tdata[OffLen +: LEN_BITS]);
    end
    if (best_upd) begin
      best_time_q <= hr_time_q;
      best_type_q <= hr_type_q;
      best_pay_q  <= hr_pay_q;
      best_id_q   <= hr_id_q;
      best_prio_q <= hr_prio_q;
      best_addr_q <= hr_addr_q;
    end
    if (out_load) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_time_q   <= out_time_d;
      out_type_q   <= out_type_d;
      out_pay_q    <= out_pay_d;
      out_last_q   <= out_last_d;
    end
  end

  // Queue memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_time[q_waddr] <= q_wtime;
      q_type[q_waddr] <= q_wtype;
      q_pay[q_waddr]  <= q_wpay;
      q_id[q_waddr]   <= q_wid;
    end
    qr_time_q <= q_time[rd_addr];
    qr_type_q <= q_type[rd_addr];
    qr_pay_q  <= q_pay[rd_addr];
    qr_id_q   <= q_id[rd_addr];
  end

  // Hit memory; the priority is looked up once, when the hit is stored.
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_time[got_q[HIT_AW-1:0]] <= qr_time_q;
      h_type[got_q[HIT_AW-1:0]] <= qr_type_q;
      h_pay[got_q[HIT_AW-1:0]]  <= qr_pay_q;
      h_id[got_q[HIT_AW-1:0]]   <= qr_id_q;
      h_prio[got_q[HIT_AW-1:0]] <= prio_of(prio_tbl_q, qr_type_q, TypeCount);
    end
    hr_time_q <= h_time[scan_q[HIT_AW-1:0]];
    hr_type_q <= h_type[scan_q[HIT_AW-1:0]];
    hr_pay_q  <= h_pay[scan_q[HIT_AW-1:0]];
    hr_id_q   <= h_id[scan_q[HIT_AW-1:0]];
    hr_prio_q <= h_prio[scan_q[HIT_AW-1:0]];
    hr_addr_q <= scan_q[HIT_AW-1:0];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OutTW'({out_pay_q, out_type_q, out_time_q, out_id_q});

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(QueueDepth))
    else $error("queue fill count exceeds depth");

  a_hit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (got_q <= lim_q))
    else $error("hit count exceeds delivery limit");

  a_emit_has_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> best_v_q)
    else $error("emitting without a selected event");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN || state_q == S_SCAN) |-> !s_axis_tready)
    else $error("request accepted during a pop");
`endif

endmodule

// File: dv/twewq_scoreboard.sv
// Scoreboard for the event window queue: predicts each transaction and checks every result.
module twewq_scoreboard (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [159:0] s_data_i,
  input  logic         s_user_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [119:0] m_data_i,
  input  logic [1:0]   m_user_i,
  input  logic         m_last_i,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [31:0]  cfg_data_i,
  output int           outstanding_o,
  output int           fail_count_o
);
  import twewq_pkg::*;

  localparam int Depth = 64;
  localparam int HitLimit = 64;

  typedef struct {
    logic [47:0] ev_time;
    logic [2:0]  ev_type;
    logic [31:0] ev_payload;
    logic [31:0] ev_id;
  } queued_event_t;

  typedef struct {
    status_e     status;
    logic [31:0] id;
    logic [47:0] ev_time;
    logic [2:0]  ev_type;
    logic [31:0] ev_payload;
    logic        last;
  } queue_result_t;

  queued_event_t stored_events[$];
  queue_result_t expected_results[$];
  logic [31:0]   prio_table;
  logic [31:0]   next_id;
  int            fails;

  assign outstanding_o = expected_results.size();
  assign fail_count_o  = fails;

  function automatic logic [3:0] type_rank(input logic [2:0] ty);
    return prio_table[ty*4 +: 4];
  endfunction

  function automatic queue_result_t make_result(input status_e st, input logic [31:0] id,
                                                input queued_event_t ev, input logic last);
    queue_result_t r;
    r.status     = st;
    r.id         = id;
    r.ev_time    = ev.ev_time;
    r.ev_type    = ev.ev_type;
    r.ev_payload = ev.ev_payload;
    r.last       = last;
    return r;
  endfunction

  // Takes a fresh id and stores the event unless the queue is full.
  task automatic store_event(input queued_event_t ev, output bit stored, output logic [31:0] id);
    id = next_id;
    next_id = next_id + 1;
    stored = stored_events.size() < Depth;
    if (stored) begin
      ev.ev_id = id;
      stored_events.push_back(ev);
    end
  endtask

  task automatic predict_request(input logic kind, input logic [159:0] d);
    queued_event_t ev, zero_ev, key;
    queued_event_t drained[$];
    queued_event_t hits[$];
    logic [48:0]   win_start, win_end;
    int            limit, j;
    bit            stored;
    logic [31:0]   id;
    zero_ev = '{default: '0};
    if (kind == KIND_SCHEDULE) begin
      ev.ev_time    = d[47:0];
      ev.ev_type    = d[50:48];
      ev.ev_payload = d[82:51];
      ev.ev_id      = '0;
      store_event(ev, stored, id);
      expected_results.push_back(make_result(stored ? ST_STORED : ST_DROPPED, id, zero_ev, 1'b1));
      return;
    end
    win_start = {1'b0, d[130:83]};
    win_end   = win_start + d[146:131];
    limit     = d[153:147];
    if (limit > HitLimit) limit = HitLimit;
    if (stored_events.size() == 0 || limit == 0) begin
      expected_results.push_back(make_result(ST_NONE, '0, zero_ev, 1'b1));
      return;
    end
    drained = stored_events;
    stored_events.delete();
    foreach (drained[i]) begin
      if ({1'b0, drained[i].ev_time} >= win_start && {1'b0, drained[i].ev_time} < win_end) begin
        if (hits.size() < limit) hits.push_back(drained[i]);
      end else begin
        store_event(drained[i], stored, id);
      end
    end
    if (hits.size() == 0) begin
      expected_results.push_back(make_result(ST_NONE, '0, zero_ev, 1'b1));
      return;
    end
    // Stable insertion sort on time, then type priority.
    for (int i = 1; i < hits.size(); i++) begin
      key = hits[i];
      j = i;
      while (j > 0 && (hits[j-1].ev_time > key.ev_time ||
             (hits[j-1].ev_time == key.ev_time &&
              type_rank(hits[j-1].ev_type) > type_rank(key.ev_type)))) begin
        hits[j] = hits[j-1];
        j--;
      end
      hits[j] = key;
    end
    foreach (hits[i])
      expected_results.push_back(make_result(ST_DELIVERED, hits[i].ev_id, hits[i],
                                             i == hits.size() - 1));
  endtask

  task automatic check_result();
    queue_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result status=%0d tdata=%h last=%b",
               $time, m_user_i, m_data_i, m_last_i);
      fails++;
      return;
    end
    want = expected_results.pop_front();
    if (m_user_i !== want.status) begin
      $display("%0t: status expected %0d actual %0d", $time, want.status, m_user_i);
      fails++;
    end
    if (m_data_i[31:0] !== want.id) begin
      $display("%0t: id expected %h actual %h", $time, want.id, m_data_i[31:0]);
      fails++;
    end
    if (m_data_i[79:32] !== want.ev_time) begin
      $display("%0t: time expected %h actual %h", $time, want.ev_time, m_data_i[79:32]);
      fails++;
    end
    if (m_data_i[82:80] !== want.ev_type) begin
      $display("%0t: type expected %0d actual %0d", $time, want.ev_type, m_data_i[82:80]);
      fails++;
    end
    if (m_data_i[114:83] !== want.ev_payload) begin
      $display("%0t: payload expected %h actual %h", $time, want.ev_payload, m_data_i[114:83]);
      fails++;
    end
    if (m_last_i !== want.last) begin
      $display("%0t: last expected %b actual %b", $time, want.last, m_last_i);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_events.delete();
      expected_results.delete();
      prio_table = PRIO_TABLE_RESET;
      next_id    = '0;
      fails      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) prio_table = cfg_data_i;
      if (m_valid_i && m_ready_i) check_result();
      if (s_valid_i && s_ready_i) predict_request(s_user_i, s_data_i);
    end
  end

endmodule

// File: dv/tb_timestamped_event_window_queue_unit.sv
// Testbench top of the event window queue: stimulus, receiver stalls and the verdict.
module tb_timestamped_event_window_queue_unit;
  import twewq_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         s_valid, s_ready, s_user;
  logic [159:0] s_data;
  logic         m_valid, m_ready, m_last;
  logic [119:0] m_data;
  logic [1:0]   m_user;
  logic         cfg_valid, cfg_ready;
  logic [31:0]  cfg_data;
  int           outstanding, fail_count;
  int           tx_idle_pct, rx_idle_pct;
  bit           hold_request;
  logic [47:0]  time_base;

  timestamped_event_window_queue_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tuser(m_user), .m_axis_tlast(m_last),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  twewq_scoreboard scoreboard (
    .clk_i(clk), .rst_ni(rst_n),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .m_last_i(m_last), .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_data_i(cfg_data), .outstanding_o(outstanding), .fail_count_o(fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("timestamped_event_window_queue_unit verification failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offers one request transaction and returns at the edge that accepts it.
  task automatic send_request(input logic kind, input logic [47:0] ev_time,
                              input logic [2:0] ev_type, input logic [31:0] ev_payload,
                              input logic [47:0] win_start, input logic [15:0] win_len,
                              input logic [6:0] max_cnt);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_user  <= kind;
    s_data  <= {6'b0, max_cnt, win_len, win_start, ev_payload, ev_type, ev_time};
    s_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (s_ready) break;
    end
    @(posedge clk);
  endtask

  task automatic schedule_event(input logic [47:0] t, input logic [2:0] ty,
                                input logic [31:0] p);
    send_request(KIND_SCHEDULE, t, ty, p, 48'({$urandom(), $urandom()}), 16'($urandom()),
                 7'($urandom()));
  endtask

  task automatic pop_window(input logic [47:0] st, input logic [15:0] len, input logic [6:0] mc);
    send_request(KIND_POP, 48'({$urandom(), $urandom()}), 3'($urandom()), $urandom(),
                 st, len, mc);
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  // The first edge lets the scoreboard record the transaction accepted last.
  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_priorities(input logic [31:0] tbl);
    drain_results();
    cfg_data  <= tbl;
    cfg_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed traffic around a moving time base so windows hit queued events.
  task automatic random_traffic(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        schedule_event(time_base + 48'($urandom_range(0, 200)), 3'($urandom()), $urandom());
      end else if (pick < 90) begin
        pop_window(time_base + 48'($urandom_range(0, 150)), 16'($urandom_range(0, 300)),
                   7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 64)));
        if ($urandom_range(0, 3) == 0) time_base = time_base + 48'($urandom_range(0, 100));
      end else if (pick < 95) begin
        schedule_event(48'({$urandom(), $urandom()}), 3'($urandom()), $urandom());
      end else begin
        pop_window(48'({$urandom(), $urandom()}), 16'($urandom()), 7'($urandom()));
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    s_valid      = 1'b0;
    s_user       = 1'b0;
    s_data       = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    hold_request = 1'b0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    time_base    = 48'h0000_1000_0000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, field extremes, ties on time, oversize and zero max_count.
    pop_window('0, 16'hFFFF, 7'd64);
    schedule_event('0, 3'd0, '0);
    schedule_event('1, 3'd7, '1);
    schedule_event(48'd100, 3'd5, 32'hA5A5_A5A5);
    schedule_event(48'd100, 3'd2, 32'h5A5A_5A5A);
    schedule_event(48'd100, 3'd2, 32'h1234_5678);
    schedule_event(48'd50, 3'd7, 32'h0F0F_0F0F);
    pop_window('0, 16'hFFFF, 7'd0);
    pop_window(48'd1000, 16'd10, 7'd64);
    pop_window(48'd50, 16'd51, 7'd127);
    pop_window('1, 16'hFFFF, 7'd1);
    pop_window('0, 16'd1, 7'd64);
    pop_window('0, 16'd0, 7'd64);
    write_priorities(32'h0123_4567);
    for (int t = 0; t < 8; t++) schedule_event(48'd7, t[2:0], t);
    pop_window(48'd7, 16'd1, 7'd5);
    pop_window(48'd7, 16'd1, 7'd64);
    write_priorities(32'hFFFF_FFFF);

    tx_idle_pct = 38;
    rx_idle_pct = 80;
    random_traffic(60);
    write_priorities(32'h0000_0000);

    // Long receiver hold-off, then more schedules than the queue holds: the queue fills and drops.
    tx_idle_pct = 0;
    hold_request = 1'b1;
    for (int i = 0; i < 70; i++) schedule_event(time_base + 48'(i), 3'($urandom()), $urandom());
    pop_window(time_base, 16'd80, 7'd64);
    write_priorities($urandom());

    tx_idle_pct = 80;
    rx_idle_pct = 38;
    random_traffic(60);
    write_priorities(32'h7654_3210);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_traffic(60);
    drain_results();

    if (fail_count == 0) begin
      $display("timestamped_event_window_queue_unit verification clean");
    end else begin
      $display("timestamped_event_window_queue_unit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/twewq_pkg.sv
design/timestamped_event_window_queue_unit.sv
dv/twewq_scoreboard.sv
dv/tb_timestamped_event_window_queue_unit.sv
